FILE: rtl/prime_gcd_pair_counter_unit_assert.svh
// Assertion macros for the prime gcd pair counter
`ifndef PRIME_GCD_PAIR_COUNTER_UNIT_ASSERT_SVH
`define PRIME_GCD_PAIR_COUNTER_UNIT_ASSERT_SVH
// implication checked on every clock, held off in reset
`define PGC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PGC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/pgc_pkg.sv
//------------------------------------------------------------------------------
// pgc_pkg
// Shared widths and constants for the prime gcd pair counter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package pgc_pkg;
    localparam int MAX_N   = 65536;
    localparam int BND_W   = 17;
    localparam int CNT_W   = 33;
    localparam int PRE_W   = 20;
    localparam int ADDR_W  = 17;
    localparam int PRIME_D = 8192;
    localparam int PIDX_W  = 13;
    localparam int ACC_W   = 64;

    // divider request / status
    typedef struct packed {
        logic             start;
        logic [BND_W-1:0] num;
        logic [BND_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [BND_W-1:0] quo;
    } t_div_rsp;
endpackage

FILE: rtl/pgc_divider.sv
//------------------------------------------------------------------------------
// pgc_divider
// Restoring bit-serial divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module pgc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pgc_pkg::t_div_req i_req,
    output pgc_pkg::t_div_rsp o_rsp
);
    import pgc_pkg::*;

    localparam int CW = $clog2(BND_W + 1);

    logic [BND_W-1:0] r_quo, n_quo;
    logic [BND_W:0]   r_rem, n_rem;
    logic [BND_W-1:0] r_den, n_den;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [BND_W:0]   w_trial;
    logic [BND_W:0]   w_diff;

    assign w_trial = {r_rem[BND_W-1:0], r_quo[BND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = CW'(BND_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[BND_W]) begin
                n_rem = w_diff;
                n_quo = {r_quo[BND_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[BND_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

FILE: rtl/prime_gcd_pair_counter_unit.sv
//------------------------------------------------------------------------------
// prime_gcd_pair_counter_unit
// Counts ordered pairs (x,y), x<=n, y<=m, whose gcd is prime.
//------------------------------------------------------------------------------
// After reset the block clears its tables and then runs a linear sieve over
// 2..65536 that fills the Mobius, prefix and prime memories; busy stays high
// throughout, and each composite marked takes one step with a serial division.
// A query then walks the blocks of equal quotients, at most about
// 2*(sqrt(n)+sqrt(m)) of them and never more than min(n,m); each block runs four
// serial divisions on the one shared divider, plus the memory reads and the
// accumulate. An out-of-range or zero bound skips the walk: the block goes from
// the first query state straight to the output state. The result is on the
// outputs for one cycle with o_valid; it cannot be stalled. A new item may be
// taken in the cycle that the result appears.
`timescale 1ns / 1ps
`include "prime_gcd_pair_counter_unit_assert.svh"
module prime_gcd_pair_counter_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [pgc_pkg::BND_W-1:0] i_bound_a,
    input  logic [pgc_pkg::BND_W-1:0] i_bound_b,
    output logic                      o_valid,
    output logic [pgc_pkg::CNT_W-1:0] o_pair_count,
    output logic                      o_out_of_range
);
    import pgc_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0,  S_IHDR  = 5'd1,  S_IRDM = 5'd2,
                           S_IPRM  = 5'd4,  S_IK    = 5'd5,
                           S_IKW   = 5'd6,  S_IKP   = 5'd7,  S_IKD  = 5'd8,
                           S_IKDW  = 5'd9,  S_IFIN  = 5'd10, S_IFW  = 5'd11,
                           S_IDLE  = 5'd12, S_QN    = 5'd13, S_QM   = 5'd14,
                           S_JN    = 5'd15, S_JM    = 5'd16, S_RD   = 5'd17,
                           S_RDW   = 5'd18, S_MUL   = 5'd19, S_ACC  = 5'd20,
                           S_OUT   = 5'd21, S_IPRE  = 5'd22;

    localparam logic [1:0] MU_ZERO = 2'b00, MU_POS = 2'b01, MU_NEG = 2'b11;

    // memories (mu, raw f then prefix F, composite marks, primes)
    logic [1:0]        mem_mu [0:MAX_N];
    logic [PRE_W-1:0]  mem_pf [0:MAX_N];
    logic              mem_cm [0:MAX_N];
    logic [BND_W-1:0]  mem_pr [0:PRIME_D-1];

    logic [4:0]        r_st, n_st;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [PIDX_W:0]   r_k, n_k, r_pt, n_pt;
    logic [BND_W-1:0]  r_p, n_p;
    logic [1:0]        r_mui, n_mui;
    logic [PRE_W-1:0]  r_fi, n_fi;
    logic [BND_W-1:0]  r_n, n_n, r_m, n_m, r_qn, n_qn, r_qm, n_qm, r_j, n_j;
    logic [CNT_W-1:0]  r_acc, n_acc;
    logic [PRE_W-1:0]  r_fa, n_fa, r_fb, n_fb;
    logic [CNT_W-1:0]  r_prod, n_prod;
    logic              r_oor, n_oor;
    logic              r_vld, n_vld;

    // memory ports
    logic              mu_we, pf_we, cm_we, pr_we;
    logic [ADDR_W-1:0] mu_wa, pf_wa, cm_wa, mu_ra, pf_ra, cm_ra;
    logic [1:0]        mu_wd, r_mu_rd;
    logic [PRE_W-1:0]  pf_wd, r_pf_rd;
    logic              cm_wd, r_cm_rd;
    logic [PIDX_W-1:0] pr_wa, pr_ra;
    logic [BND_W-1:0]  pr_wd, r_pr_rd;

    t_div_req w_req;
    t_div_rsp w_rsp;
    pgc_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_ff @(posedge i_clk) begin
        if (mu_we) mem_mu[mu_wa] <= mu_wd;
        if (pf_we) mem_pf[pf_wa] <= pf_wd;
        if (cm_we) mem_cm[cm_wa] <= cm_wd;
        if (pr_we) mem_pr[pr_wa] <= pr_wd;
        r_mu_rd <= mem_mu[mu_ra];
        r_pf_rd <= mem_pf[pf_ra];
        r_cm_rd <= mem_cm[cm_ra];
        r_pr_rd <= mem_pr[pr_ra];
    end

    logic [2*BND_W-1:0] w_t;
    logic [2*BND_W-1:0] w_qq;
    logic [PRE_W-1:0]   w_df;
    logic [CNT_W-1:0]   w_dfx;
    logic [CNT_W-1:0]   w_term;
    assign w_t    = r_p * r_i;
    assign w_qq   = r_qn * r_qm;
    assign w_df   = r_fb - r_fa;
    // count only kept modulo 2^CNT_W, so the term is too
    assign w_dfx  = {{(CNT_W-PRE_W){w_df[PRE_W-1]}}, w_df};
    assign w_term = r_prod * w_dfx;

    always_comb begin
        n_st = r_st; n_i = r_i; n_k = r_k; n_pt = r_pt; n_p = r_p;
        n_mui = r_mui; n_fi = r_fi;
        n_n = r_n; n_m = r_m; n_qn = r_qn; n_qm = r_qm; n_j = r_j;
        n_acc = r_acc; n_fa = r_fa; n_fb = r_fb; n_prod = r_prod;
        n_oor = r_oor; n_vld = 1'b0;
        mu_we = 1'b0; pf_we = 1'b0; cm_we = 1'b0; pr_we = 1'b0;
        mu_wa = r_i; pf_wa = r_i; cm_wa = r_i;
        mu_wd = MU_ZERO; pf_wd = '0; cm_wd = 1'b0;
        mu_ra = r_i; pf_ra = r_i; cm_ra = r_i;
        pr_wa = r_pt[PIDX_W-1:0]; pr_wd = ADDR_W'(r_i); pr_ra = r_k[PIDX_W-1:0];
        w_req = '0;
        unique case (r_st)
            S_CLR: begin
                // clear all entries (mu(1) is set to +1), one per cycle
                mu_we = 1'b1; pf_we = 1'b1; cm_we = 1'b1;
                mu_wd = (r_i == ADDR_W'(1)) ? MU_POS : MU_ZERO;
                if (r_i == ADDR_W'(MAX_N)) begin
                    n_i = ADDR_W'(2); n_pt = '0; n_st = S_IHDR;
                end else n_i = r_i + 1'b1;
            end
            S_IHDR: n_st = S_IRDM;       // read issued at r_i
            S_IRDM: begin
                if (!r_cm_rd) begin
                    n_st = S_IPRM;
                end else begin
                    n_mui = r_mu_rd; n_fi = r_pf_rd; n_k = '0; n_st = S_IK;
                end
            end
            S_IPRM: begin
                pr_we = 1'b1; n_pt = r_pt + 1'b1;
                mu_we = 1'b1; mu_wd = MU_NEG; pf_we = 1'b1; pf_wd = PRE_W'(1);
                n_mui = MU_NEG; n_fi = PRE_W'(1); n_k = '0; n_st = S_IK;
            end
            S_IK: begin
                if (r_k == r_pt) n_st = S_IFIN;
                else n_st = S_IKW;
            end
            S_IKW: n_st = S_IKP;
            S_IKP: begin
                n_p = r_pr_rd;
                n_st = S_IKD;
                w_req.start = 1'b1; w_req.num = BND_W'(r_i); w_req.den = r_pr_rd;
            end
            S_IKD: begin
                if (w_t > (2*BND_W)'(MAX_N)) n_st = S_IFIN;
                else n_st = S_IKDW;
            end
            S_IKDW: if (w_rsp.done) begin
                cm_we = 1'b1; cm_wd = 1'b1; cm_wa = ADDR_W'(w_t);
                mu_we = 1'b1; mu_wa = ADDR_W'(w_t);
                pf_we = 1'b1; pf_wa = ADDR_W'(w_t);
                if (BND_W'(w_rsp.quo * r_p) == BND_W'(r_i)) begin
                    mu_wd = MU_ZERO;
                    pf_wd = {{(PRE_W-2){r_mui[1]}}, r_mui};
                    n_st = S_IFIN;
                end else begin
                    mu_wd = (r_mui == MU_NEG) ? MU_POS
                          : (r_mui == MU_POS) ? MU_NEG : MU_ZERO;
                    pf_wd = {{(PRE_W-2){r_mui[1]}}, r_mui} - r_fi;
                    n_k = r_k + 1'b1; n_st = S_IK;
                end
            end
            S_IFIN: begin
                pf_ra = r_i - 1'b1; n_st = S_IFW;
            end
            S_IFW: begin
                pf_ra = r_i - 1'b1; n_st = S_IPRE;
            end
            S_IPRE: begin
                pf_we = 1'b1; pf_wd = r_fi + r_pf_rd;
                if (r_i == ADDR_W'(MAX_N)) n_st = S_IDLE;
                else begin n_i = r_i + 1'b1; n_st = S_IHDR; end
            end
            S_IDLE: if (start) begin
                n_acc = '0; n_i = ADDR_W'(1);
                n_oor = (i_bound_a > BND_W'(MAX_N)) || (i_bound_b > BND_W'(MAX_N));
                n_n = (i_bound_a < i_bound_b) ? i_bound_a : i_bound_b;
                n_m = (i_bound_a < i_bound_b) ? i_bound_b : i_bound_a;
                n_st = S_QN;
                w_req.start = 1'b1;
                w_req.num = (i_bound_a < i_bound_b) ? i_bound_a : i_bound_b;
                w_req.den = BND_W'(1);
            end
            S_QN: begin
                if (r_oor || r_n == '0 || BND_W'(r_i) > r_n) n_st = S_OUT;
                else if (w_rsp.done) begin
                    n_qn = w_rsp.quo; n_st = S_QM;
                    w_req.start = 1'b1; w_req.num = r_m; w_req.den = BND_W'(r_i);
                end
            end
            S_QM: if (w_rsp.done) begin
                n_qm = w_rsp.quo; n_st = S_JN;
                w_req.start = 1'b1; w_req.num = r_n; w_req.den = r_qn;
            end
            S_JN: if (w_rsp.done) begin
                n_j = w_rsp.quo; n_st = S_JM;
                w_req.start = 1'b1; w_req.num = r_m; w_req.den = r_qm;
            end
            S_JM: if (w_rsp.done) begin
                if (w_rsp.quo < r_j) n_j = w_rsp.quo;
                n_st = S_RD;
            end
            S_RD: begin
                pf_ra = ADDR_W'(r_j); n_st = S_RDW;
            end
            S_RDW: begin
                n_fb = r_pf_rd; pf_ra = r_i - 1'b1; n_st = S_MUL;
            end
            S_MUL: begin
                n_fa = r_pf_rd; n_prod = w_qq[CNT_W-1:0]; n_st = S_ACC;
            end
            S_ACC: begin
                n_acc = r_acc + w_term;
                n_i = ADDR_W'(r_j) + 1'b1;
                n_st = S_QN;
                w_req.start = 1'b1; w_req.num = r_n; w_req.den = BND_W'(r_j) + 1'b1;
            end
            S_OUT: begin
                n_vld = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_i   <= '0;
            r_vld <= 1'b0;
            r_pt  <= '0;
        end else begin
            r_st  <= n_st;
            r_i   <= n_i;
            r_vld <= n_vld;
            r_pt  <= n_pt;
        end
        r_k <= n_k; r_p <= n_p; r_mui <= n_mui; r_fi <= n_fi;
        r_n <= n_n; r_m <= n_m; r_qn <= n_qn; r_qm <= n_qm; r_j <= n_j;
        r_acc <= n_acc; r_fa <= n_fa; r_fb <= n_fb; r_prod <= n_prod; r_oor <= n_oor;
    end

    assign busy           = (r_st != S_IDLE);
    assign o_valid        = r_vld;
    assign o_pair_count   = r_oor ? '0 : r_acc;
    assign o_out_of_range = r_oor;

    `PGC_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
    `PGC_ASSERT_IMP(a_vld_idle, o_valid, r_st == S_IDLE, "result outside idle")
    `PGC_ASSERT_IMP(a_oor_zero, o_valid && o_out_of_range, o_pair_count == '0, "oor count")
endmodule
